>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the distance relay.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hwddr_pkg.sv
// Shared widths, codes, control word types and microprogram of the distance relay.
package hwddr_pkg;

  // Sample format and window length.
  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_LEN = 23;
  localparam int CNT_W      = $clog2(WINDOW_LEN);

  // Setting formats.
  localparam int COEF_W = 16;
  localparam int SUM_W  = 25;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Fixed-point shifts: Q8.8 drops are scaled by 2^14 to reach 22 fractional bits.
  localparam int SHIFT_DROP = 14;
  localparam int SHIFT_OUT  = 22;

  // Datapath widths.
  localparam int MEM_W  = SAMPLE_W + 2;
  localparam int VM_W   = SAMPLE_W + 3;
  localparam int MA_W   = (SAMPLE_W + 3 > 19) ? SAMPLE_W + 3 : 19;
  localparam int MB_W   = COEF_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int Z_W    = SAMPLE_W + 20;
  localparam int ZLO_W  = MA_W - 1;
  localparam int ZHI_W  = Z_W - ZLO_W;
  localparam int ACC_W  = SAMPLE_W + 39;
  localparam int DEV_W  = ACC_W - SHIFT_OUT;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PHASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_R_COEF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L_COEF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_K_COEF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd5;

  // Loop type and phase codes.
  localparam logic LOOP_GROUND = 1'b0;
  localparam logic LOOP_PHASE  = 1'b1;
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  // Microprogram geometry.
  localparam int PROG_LEN = 12;
  localparam int STEP_W   = $clog2(PROG_LEN);
  localparam logic [STEP_W-1:0] STEP_ABS = STEP_W'(8);

  typedef enum logic [2:0] {
    MA_CP  = 3'd0,
    MA_DP  = 3'd1,
    MA_S0  = 3'd2,
    MA_DS0 = 3'd3,
    MA_ZLO = 3'd4,
    MA_ZHI = 3'd5
  } mul_a_sel_t;

  typedef enum logic [1:0] {
    MB_R = 2'd0,
    MB_L = 2'd1,
    MB_K = 2'd2
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    ACC_NOP   = 3'd0,
    ACC_LOAD  = 3'd1,
    ACC_SUB14 = 3'd2,
    ACC_SUB0  = 3'd3,
    ACC_SUBZ  = 3'd4,
    ACC_ABS   = 3'd5,
    ACC_ROUND = 3'd6
  } acc_op_t;

  typedef enum logic [1:0] {
    Z_NOP  = 2'd0,
    Z_LOAD = 2'd1,
    Z_ADD  = 2'd2
  } z_op_t;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_SUM  = 2'd1,
    FIN_DONE = 2'd2
  } fin_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  // Controls that the sequencer hands to the arithmetic datapath.
  typedef struct packed {
    mul_a_sel_t ma;
    mul_b_sel_t mb;
    acc_op_t    acc;
    z_op_t      z;
  } dp_ctrl_t;

  // One microinstruction.
  typedef struct packed {
    dp_ctrl_t          dp;
    fin_op_t           fin;
    logic              jmp_phase;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Each step issues a multiply; a step that uses a product takes the one of the step before.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{dp: '{ma: MA_CP, mb: MB_R, acc: ACC_NOP, z: Z_NOP},
          fin: FIN_NONE, jmp_phase: 1'b0, target: '0};
    case (int'(step))
      0: begin
        w.dp.ma = MA_CP;   w.dp.mb = MB_R; w.dp.acc = ACC_LOAD;
      end
      1: begin
        w.dp.ma = MA_DP;   w.dp.mb = MB_L; w.dp.acc = ACC_SUB14;
      end
      2: begin
        w.dp.ma = MA_S0;   w.dp.mb = MB_R; w.dp.acc = ACC_SUB14;
        w.jmp_phase = 1'b1; w.target = STEP_ABS;
      end
      3: begin
        w.dp.ma = MA_DS0;  w.dp.mb = MB_L; w.dp.z = Z_LOAD;
      end
      4: begin
        w.dp.z = Z_ADD;
      end
      5: begin
        w.dp.ma = MA_ZLO;  w.dp.mb = MB_K;
      end
      6: begin
        w.dp.ma = MA_ZHI;  w.dp.mb = MB_K; w.dp.acc = ACC_SUB0;
      end
      7: begin
        w.dp.acc = ACC_SUBZ;
      end
      8: begin
        w.dp.acc = ACC_ABS;
      end
      9: begin
        w.dp.acc = ACC_ROUND;
      end
      10: begin
        w.fin = FIN_SUM;
      end
      11: begin
        w.fin = FIN_DONE;
      end
      default: begin
        w.fin = FIN_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/half_wave_delta_distance_relay_top.sv
// Top level of the half-wave incremental distance relay with its microcoded sequencer.
//
// Usage: one item per sample carries the three phase voltages and currents,
// the remembered pre-fault operating voltage, two trip permits and the PT-break
// flag. An item is taken on a clock edge with in_valid high and in_stall low.
// Each item yields exactly one result (latched trip, half-wave sum, window end),
// offered on out_valid and taken on an edge with out_stall low.
// Settings are written through the cfg_ channel (cfg_ready is always high) and
// must be written only while no item is in flight.
// The twelve-step microprogram runs one step per cycle on a single shared
// 19 by 17 multiplier. The phase loop jumps past the zero-sequence steps.
// The next item is taken only once the result has been registered and the
// sequencer is back in idle.
// The output register lets a new item be taken while a result waits. When the
// receiver stalls, the last microinstruction holds until the output is free.
// Synchronous reset clears the settings, the previous currents, the window sum
// and count, and the trip latch; there is no clearing pass.
module half_wave_delta_distance_relay_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [hwddr_pkg::SAMPLE_W-1:0]  in_volt_a,
  input  logic signed [hwddr_pkg::SAMPLE_W-1:0]  in_volt_b,
  input  logic signed [hwddr_pkg::SAMPLE_W-1:0]  in_volt_c,
  input  logic signed [hwddr_pkg::SAMPLE_W-1:0]  in_curr_a,
  input  logic signed [hwddr_pkg::SAMPLE_W-1:0]  in_curr_b,
  input  logic signed [hwddr_pkg::SAMPLE_W-1:0]  in_curr_c,
  input  logic signed [hwddr_pkg::MEM_W-1:0]     in_memory_voltage,
  input  logic                                   in_permit_first,
  input  logic                                   in_permit_second,
  input  logic                                   in_pt_break,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_trip,
  output logic        [hwddr_pkg::SUM_W-1:0]     out_window_sum,
  output logic                                   out_window_end,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [hwddr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [hwddr_pkg::SUM_W-1:0]     cfg_data
);

  localparam int S = hwddr_pkg::SAMPLE_W;

  // Settings.
  logic                                 loop_type_r;
  logic [1:0]                           loop_phase_r;
  logic signed [hwddr_pkg::COEF_W-1:0]  r_coef_r;
  logic signed [hwddr_pkg::COEF_W-1:0]  l_coef_r;
  logic        [hwddr_pkg::COEF_W-1:0]  k_coef_r;
  logic        [hwddr_pkg::SUM_W-1:0]   threshold_r;

  // Captured item.
  logic signed [S-1:0]                  v_r [3];
  logic signed [S-1:0]                  c_r [3];
  logic signed [hwddr_pkg::MEM_W-1:0]   mem_r;
  logic                                 permit_first_r;
  logic                                 permit_second_r;
  logic                                 pt_break_r;

  // Relay state.
  logic signed [S-1:0]                  prev_r [3];
  logic        [hwddr_pkg::SUM_W-1:0]   dev_sum_r;
  logic        [hwddr_pkg::CNT_W-1:0]   cnt_r;
  logic                                 trip_r;
  logic        [hwddr_pkg::SUM_W-1:0]   sum_r;

  // Sequencer.
  hwddr_pkg::seq_state_t                state_r, state_nxt;
  logic [hwddr_pkg::STEP_W-1:0]         step_r, step_nxt;
  hwddr_pkg::ucode_t                    cw;
  hwddr_pkg::dp_ctrl_t                  dp_ctrl;

  // Output register.
  logic                                 out_valid_r;
  logic                                 out_trip_r;
  logic        [hwddr_pkg::SUM_W-1:0]   out_sum_r;
  logic                                 out_end_r;

  // Operands.
  logic signed [S:0]                    d_cur [3];
  logic signed [S-1:0]                  vp, vq, cp, cq;
  logic signed [S:0]                    dp, dq;
  logic signed [hwddr_pkg::MA_W-1:0]    op_cp, op_dp, op_s0, op_ds0;
  logic signed [hwddr_pkg::VM_W-1:0]    op_vm;
  logic        [hwddr_pkg::DEV_W-1:0]   dev;

  logic                                 in_fire;
  logic                                 out_free;
  logic                                 done_fire;
  logic        [hwddr_pkg::DEV_W:0]     sum_wide;
  logic        [hwddr_pkg::SUM_W+1:0]   thr3;
  logic        [hwddr_pkg::SUM_W+1:0]   sum2;
  logic                                 over;
  logic                                 permit;
  logic        [hwddr_pkg::CNT_W:0]     cnt_inc;
  logic                                 wend;
  logic                                 trip_new;

  assign in_stall  = (state_r != hwddr_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Current deltas against the previous sample.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_cur[j] = (S + 1)'(c_r[j]) - (S + 1)'(prev_r[j]);
    end
  end

  // Phase selection; the unused fourth code behaves as phase A.
  always_comb begin
    case (loop_phase_r)
      hwddr_pkg::PH_B: begin
        vp = v_r[1]; vq = v_r[2]; cp = c_r[1]; cq = c_r[2]; dp = d_cur[1]; dq = d_cur[2];
      end
      hwddr_pkg::PH_C: begin
        vp = v_r[2]; vq = v_r[0]; cp = c_r[2]; cq = c_r[0]; dp = d_cur[2]; dq = d_cur[0];
      end
      default: begin
        vp = v_r[0]; vq = v_r[1]; cp = c_r[0]; cq = c_r[1]; dp = d_cur[0]; dq = d_cur[1];
      end
    endcase
  end

  // The phase loop works on the difference of the paired phases.
  always_comb begin
    if (loop_type_r == hwddr_pkg::LOOP_PHASE) begin
      op_cp = hwddr_pkg::MA_W'(cp) - hwddr_pkg::MA_W'(cq);
      op_dp = hwddr_pkg::MA_W'(dp) - hwddr_pkg::MA_W'(dq);
      op_vm = hwddr_pkg::VM_W'(vp) - hwddr_pkg::VM_W'(vq) - hwddr_pkg::VM_W'(mem_r);
    end else begin
      op_cp = hwddr_pkg::MA_W'(cp);
      op_dp = hwddr_pkg::MA_W'(dp);
      op_vm = hwddr_pkg::VM_W'(vp) - hwddr_pkg::VM_W'(mem_r);
    end
    op_s0  = hwddr_pkg::MA_W'(c_r[0]) + hwddr_pkg::MA_W'(c_r[1]) + hwddr_pkg::MA_W'(c_r[2]);
    op_ds0 = hwddr_pkg::MA_W'(d_cur[0]) + hwddr_pkg::MA_W'(d_cur[1])
           + hwddr_pkg::MA_W'(d_cur[2]);
  end

  // Fetch the control word; the datapath idles outside a run.
  always_comb begin
    cw      = hwddr_pkg::ucode(step_r);
    dp_ctrl = cw.dp;
    if (state_r != hwddr_pkg::ST_RUN) begin
      dp_ctrl.acc = hwddr_pkg::ACC_NOP;
      dp_ctrl.z   = hwddr_pkg::Z_NOP;
    end
  end

  hwddr_datapath u_dp (
    .clk    (clk),
    .ctrl   (dp_ctrl),
    .op_cp  (op_cp),
    .op_dp  (op_dp),
    .op_s0  (op_s0),
    .op_ds0 (op_ds0),
    .op_vm  (op_vm),
    .r_coef (r_coef_r),
    .l_coef (l_coef_r),
    .k_coef (k_coef_r),
    .dev    (dev)
  );

  // Saturating half-wave sum.
  assign sum_wide = (hwddr_pkg::DEV_W + 1)'(dev) + (hwddr_pkg::DEV_W + 1)'(dev_sum_r);

  // Threshold compare, raised by half on a PT break, and the permits.
  assign thr3 = (hwddr_pkg::SUM_W + 2)'(threshold_r)
              + (hwddr_pkg::SUM_W + 2)'({threshold_r, 1'b0});
  assign sum2 = (hwddr_pkg::SUM_W + 2)'({sum_r, 1'b0});
  assign over = pt_break_r ? (sum2 > thr3) : (sum_r > threshold_r);
  assign permit = (loop_type_r == hwddr_pkg::LOOP_PHASE) ?
                  (permit_first_r && permit_second_r) : permit_first_r;
  assign trip_new = trip_r || (over && permit);

  assign cnt_inc = (hwddr_pkg::CNT_W + 1)'(cnt_r) + (hwddr_pkg::CNT_W + 1)'(1);
  assign wend    = (cnt_inc >= (hwddr_pkg::CNT_W + 1)'(hwddr_pkg::WINDOW_LEN));

  assign out_free  = !out_valid_r || !out_stall;
  assign done_fire = (state_r == hwddr_pkg::ST_RUN) && (cw.fin == hwddr_pkg::FIN_DONE)
                   && out_free;

  // Step counter with the conditional jump past the zero-sequence steps.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      hwddr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = hwddr_pkg::ST_RUN;
          step_nxt  = '0;
        end
      end
      hwddr_pkg::ST_RUN: begin
        if (cw.fin == hwddr_pkg::FIN_DONE) begin
          if (out_free) begin
            state_nxt = hwddr_pkg::ST_IDLE;
            step_nxt  = '0;
          end
        end else if (cw.jmp_phase && loop_type_r == hwddr_pkg::LOOP_PHASE) begin
          step_nxt = cw.target;
        end else begin
          step_nxt = step_r + hwddr_pkg::STEP_W'(1);
        end
      end
      default: begin
        state_nxt = hwddr_pkg::ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // Control state and relay state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hwddr_pkg::ST_IDLE;
      step_r       <= '0;
      loop_type_r  <= 1'b0;
      loop_phase_r <= '0;
      r_coef_r     <= '0;
      l_coef_r     <= '0;
      k_coef_r     <= '0;
      threshold_r  <= '0;
      for (int j = 0; j < 3; j++) begin
        prev_r[j] <= '0;
      end
      dev_sum_r    <= '0;
      cnt_r        <= '0;
      trip_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hwddr_pkg::CFG_LOOP_TYPE:  loop_type_r  <= cfg_data[0];
          hwddr_pkg::CFG_LOOP_PHASE: loop_phase_r <= cfg_data[1:0];
          hwddr_pkg::CFG_R_COEF:     r_coef_r     <= cfg_data[hwddr_pkg::COEF_W-1:0];
          hwddr_pkg::CFG_L_COEF:     l_coef_r     <= cfg_data[hwddr_pkg::COEF_W-1:0];
          hwddr_pkg::CFG_K_COEF:     k_coef_r     <= cfg_data[hwddr_pkg::COEF_W-1:0];
          hwddr_pkg::CFG_THRESHOLD:  threshold_r  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (done_fire) begin
        trip_r <= trip_new;
        for (int j = 0; j < 3; j++) begin
          prev_r[j] <= c_r[j];
        end
        if (wend) begin
          cnt_r     <= '0;
          dev_sum_r <= '0;
        end else begin
          cnt_r     <= cnt_inc[hwddr_pkg::CNT_W-1:0];
          dev_sum_r <= sum_r;
        end
      end

      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      v_r[0]          <= in_volt_a;
      v_r[1]          <= in_volt_b;
      v_r[2]          <= in_volt_c;
      c_r[0]          <= in_curr_a;
      c_r[1]          <= in_curr_b;
      c_r[2]          <= in_curr_c;
      mem_r           <= in_memory_voltage;
      permit_first_r  <= in_permit_first;
      permit_second_r <= in_permit_second;
      pt_break_r      <= in_pt_break;
    end
    if (state_r == hwddr_pkg::ST_RUN && cw.fin == hwddr_pkg::FIN_SUM) begin
      sum_r <= (sum_wide >= (hwddr_pkg::DEV_W + 1)'(hwddr_pkg::SUM_MAX)) ?
               hwddr_pkg::SUM_MAX : sum_wide[hwddr_pkg::SUM_W-1:0];
    end
    if (done_fire) begin
      out_trip_r <= trip_new;
      out_sum_r  <= sum_r;
      out_end_r  <= wend;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_trip       = out_trip_r;
  assign out_window_sum = out_sum_r;
  assign out_window_end = out_end_r;

endmodule

>>> rtl/hwddr_datapath.sv
// Shared multiplier and accumulators that form the rounded loop deviation.
module hwddr_datapath (
  input  logic                                  clk,
  input  hwddr_pkg::dp_ctrl_t                   ctrl,
  input  logic signed [hwddr_pkg::MA_W-1:0]     op_cp,
  input  logic signed [hwddr_pkg::MA_W-1:0]     op_dp,
  input  logic signed [hwddr_pkg::MA_W-1:0]     op_s0,
  input  logic signed [hwddr_pkg::MA_W-1:0]     op_ds0,
  input  logic signed [hwddr_pkg::VM_W-1:0]     op_vm,
  input  logic signed [hwddr_pkg::COEF_W-1:0]   r_coef,
  input  logic signed [hwddr_pkg::COEF_W-1:0]   l_coef,
  input  logic        [hwddr_pkg::COEF_W-1:0]   k_coef,
  output logic        [hwddr_pkg::DEV_W-1:0]    dev
);

  logic signed [hwddr_pkg::MA_W-1:0]   mul_a;
  logic signed [hwddr_pkg::MB_W-1:0]   mul_b;
  logic signed [hwddr_pkg::PROD_W-1:0] prod_r;
  logic signed [hwddr_pkg::Z_W-1:0]    zacc_r;
  logic signed [hwddr_pkg::ZHI_W-1:0]  zhi;
  logic signed [hwddr_pkg::ACC_W-1:0]  acc_r;
  logic signed [hwddr_pkg::ACC_W-1:0]  prod_ext;
  logic signed [hwddr_pkg::ACC_W-1:0]  rnd;
  logic        [hwddr_pkg::DEV_W-1:0]  dev_r;

  assign zhi = zacc_r[hwddr_pkg::Z_W-1:hwddr_pkg::ZLO_W];

  always_comb begin
    case (ctrl.ma)
      hwddr_pkg::MA_CP:  mul_a = op_cp;
      hwddr_pkg::MA_DP:  mul_a = op_dp;
      hwddr_pkg::MA_S0:  mul_a = op_s0;
      hwddr_pkg::MA_DS0: mul_a = op_ds0;
      hwddr_pkg::MA_ZLO: mul_a = signed'({1'b0, zacc_r[hwddr_pkg::ZLO_W-1:0]});
      hwddr_pkg::MA_ZHI: mul_a = hwddr_pkg::MA_W'(zhi);
      default:           mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.mb)
      hwddr_pkg::MB_R: mul_b = hwddr_pkg::MB_W'(r_coef);
      hwddr_pkg::MB_L: mul_b = hwddr_pkg::MB_W'(l_coef);
      hwddr_pkg::MB_K: mul_b = signed'({1'b0, k_coef});
      default:         mul_b = '0;
    endcase
  end

  assign prod_ext = hwddr_pkg::ACC_W'(prod_r);
  assign rnd      = acc_r + (hwddr_pkg::ACC_W'(1) <<< (hwddr_pkg::SHIFT_OUT - 1));

  always_ff @(posedge clk) begin
    prod_r <= hwddr_pkg::PROD_W'(mul_a) * hwddr_pkg::PROD_W'(mul_b);

    case (ctrl.z)
      hwddr_pkg::Z_LOAD: zacc_r <= hwddr_pkg::Z_W'(prod_r);
      hwddr_pkg::Z_ADD:  zacc_r <= zacc_r + hwddr_pkg::Z_W'(prod_r);
      default:           zacc_r <= zacc_r;
    endcase

    case (ctrl.acc)
      hwddr_pkg::ACC_LOAD:  acc_r <= hwddr_pkg::ACC_W'(op_vm) <<< hwddr_pkg::SHIFT_OUT;
      hwddr_pkg::ACC_SUB14: acc_r <= acc_r - (prod_ext <<< hwddr_pkg::SHIFT_DROP);
      hwddr_pkg::ACC_SUB0:  acc_r <= acc_r - prod_ext;
      hwddr_pkg::ACC_SUBZ:  acc_r <= acc_r - (prod_ext <<< hwddr_pkg::ZLO_W);
      hwddr_pkg::ACC_ABS:   acc_r <= (acc_r < 0) ? -acc_r : acc_r;
      default:              acc_r <= acc_r;
    endcase

    if (ctrl.acc == hwddr_pkg::ACC_ROUND) begin
      dev_r <= rnd[hwddr_pkg::ACC_W-1:hwddr_pkg::SHIFT_OUT];
    end
  end

  assign dev = dev_r;

endmodule

>>> rtl/hwddr_checker.sv
// Port-level checker of the distance relay and its bind to the top level.
`include "assert_macros.svh"

module hwddr_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic                                   out_trip,
  input logic        [hwddr_pkg::SUM_W-1:0]     out_window_sum,
  input logic                                   out_window_end
);

  localparam logic [hwddr_pkg::CNT_W-1:0] WIN_LAST = hwddr_pkg::CNT_W'(hwddr_pkg::WINDOW_LEN - 1);

  logic                        seen_trip_r;
  logic [hwddr_pkg::CNT_W-1:0] win_cnt_r;
  logic                        out_fire;

  assign out_fire = out_valid && !out_stall;

  // Track delivered results: whether a trip was shown and the window position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_trip_r <= 1'b0;
      win_cnt_r   <= '0;
    end else if (out_fire) begin
      seen_trip_r <= seen_trip_r || out_trip;
      win_cnt_r   <= (win_cnt_r == WIN_LAST) ? '0 : win_cnt_r + hwddr_pkg::CNT_W'(1);
    end
  end

  `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_trip) && $stable(out_window_sum) && $stable(out_window_end), "stalled result changed")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "block took an item while another was in flight")
  `ASSERT_IMPLY(a_trip_latched, clk, rst_n, out_valid && seen_trip_r, out_trip, "trip dropped after being shown")
  `ASSERT_IMPLY(a_window_end, clk, rst_n, out_valid, out_window_end == (win_cnt_r == WIN_LAST), "window end out of step with result count")

endmodule

bind half_wave_delta_distance_relay_top hwddr_checker u_hwddr_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the half-wave incremental distance relay top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes beyond the six settings, and the phase code past phase C.
  // The block must ignore writes to the first two.
  // It must treat the phase code as phase A.
  localparam logic [hwddr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [hwddr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [1:0] PH_NONE = 2'd3;

  // Sample extremes.
  localparam int S_MAX = 32767;
  localparam int S_MIN = -32768;
  localparam int M_MAX = 131071;
  localparam int M_MIN = -131072;

  // Fixed-point scales of the operating voltage: 22 fractional bits overall,
  // and 14 more bits to bring a Q8.8 drop up to that scale.
  localparam longint Q22 = 64'sd4194304;
  localparam longint Q14 = 64'sd16384;
  localparam longint SUM_LIMIT = longint'(hwddr_pkg::SUM_MAX);

  // Upper bound on cycles spent waiting for outstanding results to drain.
  localparam int DRAIN_LIMIT = 5000;

  typedef struct {
    logic signed [hwddr_pkg::SAMPLE_W-1:0] volt_a;
    logic signed [hwddr_pkg::SAMPLE_W-1:0] volt_b;
    logic signed [hwddr_pkg::SAMPLE_W-1:0] volt_c;
    logic signed [hwddr_pkg::SAMPLE_W-1:0] curr_a;
    logic signed [hwddr_pkg::SAMPLE_W-1:0] curr_b;
    logic signed [hwddr_pkg::SAMPLE_W-1:0] curr_c;
    logic signed [hwddr_pkg::MEM_W-1:0]    memory_voltage;
    logic                                  permit_first;
    logic                                  permit_second;
    logic                                  pt_break;
  } relay_sample_t;

  typedef struct {
    logic                        trip;
    logic [hwddr_pkg::SUM_W-1:0] window_sum;
    logic                        window_end;
  } relay_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_style_t;

  // Clock, reset and the block's inputs. Every input holds a known value from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [hwddr_pkg::SAMPLE_W-1:0] in_volt_a = '0;
  logic signed [hwddr_pkg::SAMPLE_W-1:0] in_volt_b = '0;
  logic signed [hwddr_pkg::SAMPLE_W-1:0] in_volt_c = '0;
  logic signed [hwddr_pkg::SAMPLE_W-1:0] in_curr_a = '0;
  logic signed [hwddr_pkg::SAMPLE_W-1:0] in_curr_b = '0;
  logic signed [hwddr_pkg::SAMPLE_W-1:0] in_curr_c = '0;
  logic signed [hwddr_pkg::MEM_W-1:0]    in_memory_voltage = '0;
  logic in_permit_first = 1'b0;
  logic in_permit_second = 1'b0;
  logic in_pt_break = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [hwddr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hwddr_pkg::SUM_W-1:0]     cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic out_trip;
  logic [hwddr_pkg::SUM_W-1:0] out_window_sum;
  logic out_window_end;
  logic cfg_ready;

  // Settings as the relay should hold them, starting from their reset values.
  logic                                set_loop = hwddr_pkg::LOOP_GROUND;
  logic [1:0]                          set_phase = hwddr_pkg::PH_A;
  logic signed [hwddr_pkg::COEF_W-1:0] set_r = '0;
  logic signed [hwddr_pkg::COEF_W-1:0] set_l = '0;
  logic [hwddr_pkg::COEF_W-1:0]        set_k = '0;
  logic [hwddr_pkg::SUM_W-1:0]         set_threshold = '0;

  // Relay state: previous currents, the half-wave sum, its sample count and the trip.
  longint prev_curr[3] = '{0, 0, 0};
  longint window_acc = 0;
  int     window_count = 0;
  logic   trip_state = 1'b0;

  // Relay outputs predicted for accepted samples, oldest first.
  relay_result_t pending_results[$];
  int mismatches = 0;

  // Sender pacing: bursts of random length separated by random gaps.
  bit gaps_on = 1'b0;
  int max_gap = 1;
  int burst_left = 0;

  // Receiver stalling: a style for ordinary traffic, plus a long hold-off on request.
  stall_style_t stall_style = STALL_NONE;
  int hold_request = 0;
  int hold_left = 0;
  int stall_tick = 0;

  always #4 clk = ~clk;

  half_wave_delta_distance_relay_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_volt_a         (in_volt_a),
    .in_volt_b         (in_volt_b),
    .in_volt_c         (in_volt_c),
    .in_curr_a         (in_curr_a),
    .in_curr_b         (in_curr_b),
    .in_curr_c         (in_curr_c),
    .in_memory_voltage (in_memory_voltage),
    .in_permit_first   (in_permit_first),
    .in_permit_second  (in_permit_second),
    .in_pt_break       (in_pt_break),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trip          (out_trip),
    .out_window_sum    (out_window_sum),
    .out_window_end    (out_window_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Works out the relay output for one sample and advances the predicted state.
  // The operating voltage is formed exactly at 22 fractional bits. Its deviation
  // from the memory voltage is rounded half up to an integer. That value is added
  // to the half-wave sum, which saturates at the top of its 25-bit range.
  task automatic predict_relay_output(input relay_sample_t s, output relay_result_t r);
    longint v[3], c[3], d[3];
    longint mem_v, uop, dev, sum, drop, zdrop, rr, ll, kk, thr;
    int p, q, j;
    bit permit, over, wend;
    v[0] = longint'(s.volt_a); v[1] = longint'(s.volt_b); v[2] = longint'(s.volt_c);
    c[0] = longint'(s.curr_a); c[1] = longint'(s.curr_b); c[2] = longint'(s.curr_c);
    for (j = 0; j < 3; j++) d[j] = c[j] - prev_curr[j];
    mem_v = longint'(s.memory_voltage);
    rr = longint'(set_r);
    ll = longint'(set_l);
    kk = longint'(set_k);
    thr = longint'(set_threshold);
    // The unused phase code selects phase A; the phase loop pairs p with the next phase.
    p = (set_phase > hwddr_pkg::PH_C) ? int'(hwddr_pkg::PH_A) : int'(set_phase);
    q = (p + 1) % 3;
    if (set_loop == hwddr_pkg::LOOP_GROUND) begin
      drop = rr * c[p] + ll * d[p];
      zdrop = rr * (c[0] + c[1] + c[2]) + ll * (d[0] + d[1] + d[2]);
      uop = v[p] * Q22 - drop * Q14 - kk * zdrop;
      permit = s.permit_first;
    end else begin
      drop = rr * (c[p] - c[q]) + ll * (d[p] - d[q]);
      uop = (v[p] - v[q]) * Q22 - drop * Q14;
      permit = s.permit_first && s.permit_second;
    end
    dev = uop - mem_v * Q22;
    if (dev < 0) dev = -dev;
    dev = (dev + Q22 / 2) / Q22;
    sum = (dev >= SUM_LIMIT - window_acc) ? SUM_LIMIT : window_acc + dev;
    // A broken PT raises the threshold by half; the compare stays exact in integers.
    over = s.pt_break ? (2 * sum > 3 * thr) : (sum > thr);
    if (over && permit) trip_state = 1'b1;
    wend = (window_count + 1 >= hwddr_pkg::WINDOW_LEN);
    if (wend) begin
      window_count = 0;
      window_acc = 0;
    end else begin
      window_count++;
      window_acc = sum;
    end
    for (j = 0; j < 3; j++) prev_curr[j] = c[j];
    r.trip = trip_state;
    r.window_sum = sum[hwddr_pkg::SUM_W-1:0];
    r.window_end = wend;
  endtask

  // Writes one setting. The block must only see this while no sample is in flight.
  // A register keeps only its own width of the data; spare indexes change nothing.
  task automatic write_setting(input logic [hwddr_pkg::CFG_IDX_W-1:0] idx,
                               input logic [hwddr_pkg::SUM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hwddr_pkg::CFG_LOOP_TYPE:  set_loop = data[0];
      hwddr_pkg::CFG_LOOP_PHASE: set_phase = data[1:0];
      hwddr_pkg::CFG_R_COEF:     set_r = data[hwddr_pkg::COEF_W-1:0];
      hwddr_pkg::CFG_L_COEF:     set_l = data[hwddr_pkg::COEF_W-1:0];
      hwddr_pkg::CFG_K_COEF:     set_k = data[hwddr_pkg::COEF_W-1:0];
      hwddr_pkg::CFG_THRESHOLD:  set_threshold = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Between items the sender either keeps valid high or leaves a random gap.
  // Valid is lowered here only in a step where no new item is being offered.
  task automatic pace_sender();
    int gap;
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(max_gap, 1);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    burst_left = $urandom_range(12, 0);
  endtask

  // Offers one item, waits for the edge that accepts it, and records the prediction.
  // Called at a rising edge; valid stays high afterwards unless pacing lowers it.
  task automatic send_sample(input relay_sample_t s);
    relay_result_t r;
    in_valid <= 1'b1;
    in_volt_a <= s.volt_a;
    in_volt_b <= s.volt_b;
    in_volt_c <= s.volt_c;
    in_curr_a <= s.curr_a;
    in_curr_b <= s.curr_b;
    in_curr_c <= s.curr_c;
    in_memory_voltage <= s.memory_voltage;
    in_permit_first <= s.permit_first;
    in_permit_second <= s.permit_second;
    in_pt_break <= s.pt_break;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_relay_output(s, r);
    pending_results.push_back(r);
    pace_sender();
  endtask

  // Stops offering items and waits until every predicted output has arrived.
  // Every item yields one output, so a short settle afterwards is enough.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
  endtask

  function automatic relay_sample_t make_sample(
      input int va, vb, vc, ia, ib, ic,
      input int mem, input logic pf, ps, pt);
    relay_sample_t s;
    s.volt_a = hwddr_pkg::SAMPLE_W'(va);
    s.volt_b = hwddr_pkg::SAMPLE_W'(vb);
    s.volt_c = hwddr_pkg::SAMPLE_W'(vc);
    s.curr_a = hwddr_pkg::SAMPLE_W'(ia);
    s.curr_b = hwddr_pkg::SAMPLE_W'(ib);
    s.curr_c = hwddr_pkg::SAMPLE_W'(ic);
    s.memory_voltage = hwddr_pkg::MEM_W'(mem);
    s.permit_first = pf;
    s.permit_second = ps;
    s.pt_break = pt;
    return s;
  endfunction

  // Full-range samples mostly saturate the sum. Scaled-down ones keep it in range,
  // so the threshold compare and the window restart are reached with real values.
  function automatic relay_sample_t random_sample(input bit full_range);
    relay_sample_t s;
    s.volt_a = hwddr_pkg::SAMPLE_W'($urandom);
    s.volt_b = hwddr_pkg::SAMPLE_W'($urandom);
    s.volt_c = hwddr_pkg::SAMPLE_W'($urandom);
    s.curr_a = hwddr_pkg::SAMPLE_W'($urandom);
    s.curr_b = hwddr_pkg::SAMPLE_W'($urandom);
    s.curr_c = hwddr_pkg::SAMPLE_W'($urandom);
    s.memory_voltage = hwddr_pkg::MEM_W'($urandom);
    if (!full_range) begin
      s.volt_a = s.volt_a >>> 5; s.volt_b = s.volt_b >>> 5; s.volt_c = s.volt_c >>> 5;
      s.curr_a = s.curr_a >>> 7; s.curr_b = s.curr_b >>> 7; s.curr_c = s.curr_c >>> 7;
      s.memory_voltage = s.memory_voltage >>> 6;
    end
    // Trips latch for good, so the first permit is kept rare.
    s.permit_first = ($urandom_range(7, 0) == 0);
    s.permit_second = 1'($urandom);
    s.pt_break = 1'($urandom);
    return s;
  endfunction

  function automatic logic [hwddr_pkg::COEF_W-1:0] pick_coef();
    case ($urandom_range(3, 0))
      0: return 16'($urandom_range(511, 0) - 256);
      1: return 16'($urandom);
      2: return ($urandom_range(1, 0) == 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(1, 0) == 1 ? 0 : 16'hFFFF);
    endcase
  endfunction

  // Result checker: each output taken from the block is compared with the oldest
  // prediction. Outputs are sampled at the edge, so the stall seen here is the one
  // that decided the transfer.
  always @(posedge clk) begin
    relay_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("relay output arrived with no sample waiting for it");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_trip !== want.trip) begin
          $error("trip: expected %0d, actual %0d", want.trip, out_trip);
          mismatches++;
        end
        if (out_window_sum !== want.window_sum) begin
          $error("window_sum: expected %0d, actual %0d", want.window_sum, out_window_sum);
          mismatches++;
        end
        if (out_window_end !== want.window_end) begin
          $error("window_end: expected %0d, actual %0d", want.window_end, out_window_end);
          mismatches++;
        end
      end
    end
  end

  // Receiver. A hold-off request overrides the style for the requested length; the
  // pattern style stalls at the start of each repeating period.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        STALL_NONE:    out_stall <= 1'b0;
        STALL_RANDOM:  out_stall <= ($urandom_range(3, 0) == 0);
        STALL_PATTERN: out_stall <= ((stall_tick % 11) < 4);
        default:       out_stall <= ($urandom_range(9, 0) < 7);
      endcase
    end
  end

  // Runs straight after reset, while the sum still starts from zero. With all
  // coefficients zero the ground loop sees only phase A voltage, so the sum is
  // steered onto the threshold exactly. None of these samples may trip: a sum equal
  // to the threshold, a sum at exactly 1.5 times it on a broken PT, a missing
  // first permit with the second one present, and a phase loop missing one permit.
  task automatic test_threshold_boundaries();
    write_setting(hwddr_pkg::CFG_THRESHOLD, 25'd1000);
    send_sample(make_sample(600, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 400, 1'b1, 1'b0, 1'b0));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1));
    send_sample(make_sample(-500, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1));
    send_sample(make_sample(1, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0));
    wait_for_results();
    write_setting(hwddr_pkg::CFG_LOOP_TYPE, hwddr_pkg::SUM_W'(hwddr_pkg::LOOP_PHASE));
    send_sample(make_sample(10, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0));
    send_sample(make_sample(0, 7, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0));
    wait_for_results();
    // From here on no sum can pass the threshold until the random traffic.
    write_setting(hwddr_pkg::CFG_THRESHOLD, hwddr_pkg::SUM_MAX);
    write_setting(hwddr_pkg::CFG_LOOP_TYPE, hwddr_pkg::SUM_W'(hwddr_pkg::LOOP_GROUND));
  endtask

  // Extreme samples against extreme coefficients, in both signs, to push the
  // products to their widest and the sum into saturation. The last pair checks
  // the rounding of a half-unit drop.
  task automatic test_field_extremes();
    wait_for_results();
    write_setting(hwddr_pkg::CFG_R_COEF, 25'h0008000);
    write_setting(hwddr_pkg::CFG_L_COEF, 25'h0007FFF);
    write_setting(hwddr_pkg::CFG_K_COEF, 25'h000FFFF);
    gaps_on = 1'b1;
    max_gap = 14;
    stall_style = STALL_RANDOM;
    send_sample(make_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, M_MAX, 1'b0, 1'b1, 1'b1));
    send_sample(make_sample(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, M_MIN, 1'b0, 1'b0, 1'b0));
    send_sample(make_sample(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, 0, 1'b1, 1'b0, 1'b1));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    wait_for_results();
    write_setting(hwddr_pkg::CFG_R_COEF, 25'h0007FFF);
    write_setting(hwddr_pkg::CFG_L_COEF, 25'h0008000);
    write_setting(hwddr_pkg::CFG_K_COEF, 25'h0000000);
    send_sample(make_sample(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, M_MAX, 1'b1, 1'b1, 1'b1));
    send_sample(make_sample(S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, M_MIN, 1'b0, 1'b0, 1'b0));
    wait_for_results();
    // A Q8.8 resistance of one half on a one-unit current gives a half-unit deviation.
    write_setting(hwddr_pkg::CFG_R_COEF, 25'h0000080);
    write_setting(hwddr_pkg::CFG_L_COEF, 25'h0000000);
    send_sample(make_sample(0, 0, 0, 1, 0, 0, 0, 1'b0, 1'b0, 1'b0));
    send_sample(make_sample(1, 0, 0, -1, 0, 0, 0, 1'b0, 1'b0, 1'b0));
    gaps_on = 1'b0;
    stall_style = STALL_NONE;
  endtask

  // Phase loop on each pair, including the unused phase code. The zero-sequence
  // factor is left nonzero: the phase loop must not use it.
  task automatic test_phase_loops();
    logic [1:0] sel[4];
    int n;
    sel = '{hwddr_pkg::PH_A, hwddr_pkg::PH_B, hwddr_pkg::PH_C, PH_NONE};
    wait_for_results();
    write_setting(hwddr_pkg::CFG_LOOP_TYPE, hwddr_pkg::SUM_W'(hwddr_pkg::LOOP_PHASE));
    write_setting(hwddr_pkg::CFG_R_COEF, 25'h0000100);
    write_setting(hwddr_pkg::CFG_L_COEF, 25'h0000040);
    write_setting(hwddr_pkg::CFG_K_COEF, 25'h0004000);
    for (n = 0; n < 4; n++) begin
      wait_for_results();
      write_setting(hwddr_pkg::CFG_LOOP_PHASE, hwddr_pkg::SUM_W'(sel[n]));
      send_sample(make_sample(100, -200, 300, 10, -20, 30, 50, 1'b0, 1'b1, 1'b0));
      send_sample(make_sample(-400, 900, -50, 7, 9, -11, -75, 1'b1, 1'b0, 1'b1));
    end
  endtask

  // Writes carrying bits above a register's width, and writes to the spare
  // indexes, which must leave every setting as it was.
  task automatic test_setting_masks();
    wait_for_results();
    write_setting(hwddr_pkg::CFG_LOOP_TYPE, 25'h1FFFFFE);
    write_setting(hwddr_pkg::CFG_LOOP_PHASE, 25'h1FFFFF6);
    write_setting(hwddr_pkg::CFG_R_COEF, 25'h1ABFF80);
    write_setting(hwddr_pkg::CFG_L_COEF, 25'h1230040);
    write_setting(hwddr_pkg::CFG_K_COEF, 25'h1FFC000);
    write_setting(CFG_SPARE_LO, 25'h0000000);
    write_setting(CFG_SPARE_HI, 25'h1FFFFFF);
    send_sample(make_sample(1200, -800, 40, 33, -12, 5, 300, 1'b0, 1'b0, 1'b1));
    send_sample(make_sample(-90, 2500, -700, -40, 60, 22, -150, 1'b0, 1'b1, 1'b0));
  endtask

  // The receiver holds off for a long stretch while items keep coming back to
  // back, so the block fills its output register and stalls its input.
  task automatic test_backpressure();
    int n;
    wait_for_results();
    stall_style = STALL_NONE;
    gaps_on = 1'b0;
    hold_request = 300;
    for (n = 0; n < 12; n++) send_sample(random_sample(1'b0));
    wait_for_results();
  endtask

  // Random settings per phase, then random samples under a random idling style.
  // The first phase runs with no idling on either side.
  task automatic test_random_traffic();
    int phase_no, n;
    logic [hwddr_pkg::SUM_W-1:0] thr;
    for (phase_no = 0; phase_no < 10; phase_no++) begin
      wait_for_results();
      write_setting(hwddr_pkg::CFG_LOOP_TYPE, hwddr_pkg::SUM_W'($urandom));
      write_setting(hwddr_pkg::CFG_LOOP_PHASE, hwddr_pkg::SUM_W'($urandom));
      write_setting(hwddr_pkg::CFG_R_COEF, hwddr_pkg::SUM_W'({$urandom, pick_coef()}));
      write_setting(hwddr_pkg::CFG_L_COEF, hwddr_pkg::SUM_W'({$urandom, pick_coef()}));
      write_setting(hwddr_pkg::CFG_K_COEF, hwddr_pkg::SUM_W'({$urandom, pick_coef()}));
      case ($urandom_range(3, 0))
        0: thr = hwddr_pkg::SUM_MAX;
        1: thr = hwddr_pkg::SUM_W'($urandom_range(200000, 0));
        2: thr = hwddr_pkg::SUM_W'($urandom);
        default: thr = hwddr_pkg::SUM_W'($urandom_range(5000000, 1000000));
      endcase
      write_setting(hwddr_pkg::CFG_THRESHOLD, thr);
      if (phase_no == 0) begin
        stall_style = STALL_NONE;
        gaps_on = 1'b0;
      end else begin
        stall_style = stall_style_t'($urandom_range(3, 0));
        gaps_on = $urandom_range(3, 0) != 0;
        max_gap = $urandom_range(16, 1);
      end
      for (n = 0; n < 110; n++) send_sample(random_sample($urandom_range(4, 0) < 2));
    end
  endtask

  // Test sequence. Reset is held once at the start, then the directed tests
  // run before the random traffic, since a trip latches until the next reset.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_threshold_boundaries();
    test_field_extremes();
    test_phase_loops();
    test_setting_masks();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    if (pending_results.size() != 0) begin
      $error("%0d relay outputs never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, which takes well under a
  // millisecond of simulated time.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
